/* rtl/core/assert_macros.svh */
// Shared assertion macros for the filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ND(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/mop_pkg.sv */
package mop_pkg;

   localparam int unsigned MaxWidthDefault = 8192;
   localparam int unsigned PixW            = 16;
   localparam int unsigned FwW             = 14;
   localparam int unsigned FhW             = 16;
   localparam int unsigned ThrW            = 16;
   localparam int unsigned CsrIdxW         = 2;
   localparam int unsigned CsrDataW        = 16;
   localparam int unsigned SumW            = 19;
   localparam int unsigned MinDim          = 3;

   localparam logic [FwW-1:0]  FrameWidthReset  = 14'd8192;
   localparam logic [FhW-1:0]  FrameHeightReset = 16'd3;
   localparam logic [ThrW-1:0] OutlierReset     = 16'd1000;
   localparam logic [ThrW-1:0] DarkReset        = 16'd100;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_OUTLIER_THR  = 2'd2,
      CSR_DARK_THR     = 2'd3
   } csr_index_type;

   typedef logic [PixW-1:0] sample_type;
   typedef sample_type [2:0] pixel_type;

   // Per-item control carried down the pipeline.
   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } tag_type;

   function automatic sample_type min2(input sample_type a, input sample_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic sample_type max2(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic sample_type med3(input sample_type a, input sample_type b,
                                       input sample_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

/* rtl/core/median_outlier_pixel_replace.sv */
// 3x3 impulse-noise filter for a raster stream of three-channel 16-bit pixels.
// Input channel req_*: one pixel (or a flush tick, req_command = 1) per
// transaction in raster order. A frame is frame_width*frame_height pixels
// followed by frame_width+1 flush ticks.
// Result channel rsp_*: one filtered pixel per transaction, in raster order;
// rsp_frame_end marks the last pixel of a frame. Interior pixels whose channel
// strays from its 3x3 median or is too dark become the mean of their eight
// neighbors (rsp_was_replaced = 1); border pixels pass unchanged.
// Configuration port csr_*: write frame_width, frame_height and the two
// thresholds while the block is idle.
// Latency: a pixel's result is produced by the transaction that arrives
// frame_width+1 items later, and reaches rsp_* through the stage 1, window,
// stage 3, stage 4 and output registers once that transaction is accepted.
// Throughput: one transaction per cycle unless a result stalls; both line stores
// are simple dual-port RAMs, read at the input column and written from stage 1.
// Reset: counters, window, tags and control registers reset; line stores and data
// registers are not cleared (unwritten line store rows only feed the border).
// A stalled result holds the whole pipeline and raises req_stall in the same
// cycle.
module median_outlier_pixel_replace #(
   parameter int unsigned MAX_WIDTH = mop_pkg::MaxWidthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [mop_pkg::PixW-1:0]     req_pixel_ch0,
   input  logic [mop_pkg::PixW-1:0]     req_pixel_ch1,
   input  logic [mop_pkg::PixW-1:0]     req_pixel_ch2,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mop_pkg::PixW-1:0]     rsp_out_ch0,
   output logic [mop_pkg::PixW-1:0]     rsp_out_ch1,
   output logic [mop_pkg::PixW-1:0]     rsp_out_ch2,
   output logic                         rsp_was_replaced,
   output logic                         rsp_frame_end,
   input  logic                         csr_write_enable,
   input  logic [mop_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mop_pkg::CsrDataW-1:0] csr_write_data
);

   import mop_pkg::*;

   localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned WW   = $clog2(MAX_WIDTH + 2);
   localparam int unsigned CmpW = (WW > FwW) ? WW : FwW;

   // Configuration registers
   logic [FwW-1:0]  frame_width_ff;
   logic [FhW-1:0]  frame_height_ff;
   logic [ThrW-1:0] outlier_thr_ff;
   logic [ThrW-1:0] dark_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FrameWidthReset;
         frame_height_ff <= FrameHeightReset;
         outlier_thr_ff  <= OutlierReset;
         dark_thr_ff     <= DarkReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[FwW-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[FhW-1:0];
            CSR_OUTLIER_THR:  outlier_thr_ff  <= csr_write_data[ThrW-1:0];
            CSR_DARK_THR:     dark_thr_ff     <= csr_write_data[ThrW-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the frame size
   logic [CmpW-1:0] fw_ext;
   logic [WW-1:0]   eff_w;
   logic [FhW-1:0]  eff_h;

   assign fw_ext = CmpW'(frame_width_ff);
   assign eff_w  = (fw_ext < CmpW'(MinDim))    ? WW'(MinDim) :
                   (fw_ext > CmpW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
   assign eff_h  = (frame_height_ff < FhW'(MinDim)) ? FhW'(MinDim) : frame_height_ff;

   // Pipeline advance
   logic en;
   logic accept;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && en;
   assign req_stall = !en;

   // Position counters
   logic [ColW-1:0] in_col_ff, out_col_ff;
   logic [FhW-1:0]  out_row_ff;
   logic [WW-1:0]   seen_ff;

   logic [ColW-1:0] col_sel;
   logic [WW-1:0]   col_inc;
   logic [ColW-1:0] in_col_in;
   logic [WW:0]     w_p1, seen_inc;
   logic [WW-1:0]   seen_in;
   logic [WW:0]     ocol_inc;
   logic [FhW:0]    orow_ext;
   logic            ocol_last, orow_last;
   tag_type         tag_in;

   always_comb begin
      col_sel   = (WW'(in_col_ff) < eff_w) ? in_col_ff : '0;
      col_inc   = WW'(col_sel) + WW'(1);
      in_col_in = (col_inc >= eff_w) ? '0 : ColW'(col_inc);
      w_p1      = (WW+1)'(eff_w) + (WW+1)'(1);
      seen_inc  = (WW+1)'(seen_ff) + (WW+1)'(1);
      seen_in   = (seen_inc >= w_p1) ? WW'(w_p1) : WW'(seen_inc);
      ocol_inc  = (WW+1)'(out_col_ff) + (WW+1)'(1);
      orow_ext  = (FhW+1)'(out_row_ff);
      ocol_last = ocol_inc >= (WW+1)'(eff_w);
      orow_last = (orow_ext + (FhW+1)'(1)) >= (FhW+1)'(eff_h);
      tag_in.emit     = (WW+1)'(seen_ff) >= w_p1;
      tag_in.interior = (out_row_ff != '0) &&
                        ((orow_ext + (FhW+1)'(2)) <= (FhW+1)'(eff_h)) &&
                        (out_col_ff != '0) &&
                        ((ocol_inc + (WW+1)'(1)) <= (WW+1)'(eff_w));
      tag_in.last     = ocol_last && orow_last;
   end

   // Advance counters on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         seen_ff    <= '0;
      end else if (accept) begin
         if (tag_in.emit && tag_in.last) begin
            in_col_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            seen_ff    <= '0;
         end else begin
            in_col_ff <= in_col_in;
            seen_ff   <= seen_in;
            if (tag_in.emit) begin
               if (ocol_last) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + FhW'(1);
               end else begin
                  out_col_ff <= ColW'(ocol_inc);
               end
            end
         end
      end
   end

   // Stage 1: line store read pending
   logic            p1_valid_ff;
   logic [ColW-1:0] p1_addr_ff;
   pixel_type       p1_px_ff;
   tag_type         p1_tag_ff;
   pixel_type       px_in;

   assign px_in = req_command ? '0 : {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p1_tag_ff   <= '0;
      end else if (en) begin
         p1_valid_ff <= accept;
         p1_tag_ff   <= accept ? tag_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_addr_ff <= col_sel;
         p1_px_ff   <= px_in;
      end
   end

   // Line stores: read at the input column, write back from stage 1 when the pipeline advances
   pixel_type upper_rd, middle_rd;
   logic      wb_en;

   assign wb_en = en && p1_valid_ff;

   mop_ram #(.WIDTH($bits(pixel_type)), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (p1_addr_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (upper_rd)
   );

   mop_ram #(.WIDTH($bits(pixel_type)), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (p1_addr_ff),
      .wr_data (p1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (middle_rd)
   );

   // Stage 2: shift the 3x3 window
   pixel_type win_ff [3][3];
   tag_type   p2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[r][k] <= '0;
            end
         end
         p2_tag_ff <= '0;
      end else if (en) begin
         p2_tag_ff <= p1_tag_ff;
         if (p1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= upper_rd;
            win_ff[1][2] <= middle_rd;
            win_ff[2][2] <= p1_px_ff;
         end
      end
   end

   // Stage 3: sort each row, partial neighbor sums
   sample_type           p3_min_ff [3][3];
   sample_type           p3_med_ff [3][3];
   sample_type           p3_max_ff [3][3];
   logic [SumW-2:0]      p3_sum_a_ff [3];
   logic [SumW-2:0]      p3_sum_b_ff [3];
   sample_type           p3_ctr_ff [3];
   tag_type              p3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_tag_ff <= '0;
      end else if (en) begin
         p3_tag_ff <= p2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
               p3_min_ff[ch][r] <= min2(min2(win_ff[r][0][ch], win_ff[r][1][ch]),
                                        win_ff[r][2][ch]);
               p3_med_ff[ch][r] <= med3(win_ff[r][0][ch], win_ff[r][1][ch],
                                        win_ff[r][2][ch]);
               p3_max_ff[ch][r] <= max2(max2(win_ff[r][0][ch], win_ff[r][1][ch]),
                                        win_ff[r][2][ch]);
            end
            p3_sum_a_ff[ch] <= (SumW-1)'(win_ff[0][0][ch]) + (SumW-1)'(win_ff[0][1][ch]) +
                               (SumW-1)'(win_ff[0][2][ch]) + (SumW-1)'(win_ff[1][0][ch]);
            p3_sum_b_ff[ch] <= (SumW-1)'(win_ff[1][2][ch]) + (SumW-1)'(win_ff[2][0][ch]) +
                               (SumW-1)'(win_ff[2][1][ch]) + (SumW-1)'(win_ff[2][2][ch]);
            p3_ctr_ff[ch]   <= win_ff[1][1][ch];
         end
      end
   end

   // Stage 4: combine rows toward the median, finish the sum
   sample_type      p4_lo_ff [3];
   sample_type      p4_md_ff [3];
   sample_type      p4_hi_ff [3];
   logic [SumW-1:0] p4_sum_ff [3];
   sample_type      p4_ctr_ff [3];
   tag_type         p4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_tag_ff <= '0;
      end else if (en) begin
         p4_tag_ff <= p3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            p4_lo_ff[ch]  <= max2(max2(p3_min_ff[ch][0], p3_min_ff[ch][1]),
                                  p3_min_ff[ch][2]);
            p4_md_ff[ch]  <= med3(p3_med_ff[ch][0], p3_med_ff[ch][1], p3_med_ff[ch][2]);
            p4_hi_ff[ch]  <= min2(min2(p3_max_ff[ch][0], p3_max_ff[ch][1]),
                                  p3_max_ff[ch][2]);
            p4_sum_ff[ch] <= SumW'(p3_sum_a_ff[ch]) + SumW'(p3_sum_b_ff[ch]);
            p4_ctr_ff[ch] <= p3_ctr_ff[ch];
         end
      end
   end

   // Output stage: median test and replacement
   sample_type median_c [3];
   sample_type dist_c [3];
   logic [2:0] bad_c;
   logic       replace_in;
   pixel_type  res_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         median_c[ch] = med3(p4_lo_ff[ch], p4_md_ff[ch], p4_hi_ff[ch]);
         dist_c[ch]   = (p4_ctr_ff[ch] >= median_c[ch]) ? p4_ctr_ff[ch] - median_c[ch]
                                                        : median_c[ch] - p4_ctr_ff[ch];
         bad_c[ch]    = (dist_c[ch] > outlier_thr_ff) || (p4_ctr_ff[ch] < dark_thr_ff);
      end
      replace_in = p4_tag_ff.interior && (bad_c != '0);
      for (int ch = 0; ch < 3; ch++) begin
         res_in[ch] = replace_in ? p4_sum_ff[ch][SumW-1:3] : p4_ctr_ff[ch];
      end
   end

   pixel_type res_ff;
   logic      replaced_ff, frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p4_tag_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff       <= res_in;
         replaced_ff  <= replace_in;
         frame_end_ff <= p4_tag_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_ch0      = res_ff[0];
   assign rsp_out_ch1      = res_ff[1];
   assign rsp_out_ch2      = res_ff[2];
   assign rsp_was_replaced = replaced_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule

/* rtl/core/mop_ram.sv */
module mop_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/core/mop_checker.sv */
`include "assert_macros.svh"

module mop_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [mop_pkg::PixW-1:0]     rsp_out_ch0,
   input logic [mop_pkg::PixW-1:0]     rsp_out_ch1,
   input logic [mop_pkg::PixW-1:0]     rsp_out_ch2,
   input logic                         rsp_was_replaced,
   input logic                         rsp_frame_end
);

   // No result is offered right after reset
   `ASSERT_NEXT_ND(a_reset_empties_output, clock, reset, !rsp_valid)

   // Input backpressure comes only from a held result
   `ASSERT_IMP(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A held result keeps its payload
   `ASSERT_NEXT(a_held_result_stable, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_ch0) && $stable(rsp_out_ch1) && $stable(rsp_out_ch2) && $stable(rsp_was_replaced) && $stable(rsp_frame_end))

endmodule

bind median_outlier_pixel_replace mop_checker u_mop_checker (.*);
